// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; expects signals named clock and reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is high
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// implication checked on every rising clock edge, off while reset is high
`define ASSERT_IMPLIES(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/ftq_pkg.sv =====
// shared types and constants for the linked-list task queue
// no dependencies
package ftq_pkg;

   localparam int TASK_COUNT = 255;
   localparam int ID_W = 8;
   localparam int ADDR_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

   localparam logic [ID_W-1:0] NONE_ID = 8'hFF;

   // request kinds
   localparam logic REQ_POST = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic            req_type;
      logic [ID_W-1:0] task_id;
   } req_data_type;

   typedef struct packed {
      logic            ok;
      logic [ID_W-1:0] popped_task;
      logic            queue_empty;
   } rsp_data_type;

   // command bundle into the next-pointer store
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ID_W-1:0]   wr_data;
   } mem_cmd_type;

endpackage

// ===== rtl/core/ftq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ftq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ftq_next_store.sv =====
// next-pointer table: ram plus per-entry written flags so unwritten entries read as none
// depends on ftq_pkg and ftq_ram
module ftq_next_store (
   input  logic                        clock,
   input  logic                        reset,
   input  ftq_pkg::mem_cmd_type        cmd,
   output logic [ftq_pkg::ID_W-1:0]    rd_next
);

   logic [ftq_pkg::TASK_COUNT-1:0] written_ff;
   logic [ftq_pkg::TASK_COUNT-1:0] written_in;
   logic                           rd_written_ff;
   logic                           rd_written_in;
   logic [ftq_pkg::ID_W-1:0]       ram_q;

   ftq_ram #(
      .WIDTH (ftq_pkg::ID_W),
      .DEPTH (ftq_pkg::TASK_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_q)
   );

   // flag update and flag sample alongside the ram read
   always_comb begin
      written_in = written_ff;
      if (cmd.wr_en) begin
         written_in[cmd.wr_addr] = 1'b1;
      end
      rd_written_in = rd_written_ff;
      if (cmd.rd_en) begin
         rd_written_in = written_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff    <= written_in;
         rd_written_ff <= rd_written_in;
      end
   end

   // never-written entries hold none
   assign rd_next = rd_written_ff ? ram_q : ftq_pkg::NONE_ID;

endmodule

// ===== rtl/core/fifo_task_queue_dedup.sv =====
// task queue kept as a linked list in a next-pointer ram, with dedup on post
// the result beat is registered from the exec state that follows the accepted request beat
// one request at a time: the exec state waits on the registered next-pointer ram read
// a held result stalls the update cycle until the result beat is taken
// reset: head and tail go to none and all table entries read as none at once, no clearing pass
// depends on ftq_pkg, ftq_next_store, assert_macros.svh
`include "assert_macros.svh"

module fifo_task_queue_dedup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ftq_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ftq_pkg::rsp_data_type rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                 state_ff, state_in;
   logic [ftq_pkg::ID_W-1:0]  head_ff, head_in;
   logic [ftq_pkg::ID_W-1:0]  tail_ff, tail_in;
   logic                      req_type_ff, req_type_in;
   logic [ftq_pkg::ID_W-1:0]  id_ff, id_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ftq_pkg::rsp_data_type     rsp_data_ff, rsp_data_in;

   ftq_pkg::mem_cmd_type      cmd;
   logic [ftq_pkg::ID_W-1:0]  rd_next;
   logic                      accept;
   logic [ftq_pkg::ID_W-1:0]  rd_id;
   logic                      rd_in_range;
   logic                      id_in_range;
   logic                      waiting;
   logic                      exec_go;

   ftq_next_store u_next (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_next (rd_next)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // read address: posted id, or current head for a pop
   assign rd_id       = (req_data.req_type == ftq_pkg::REQ_POP) ? head_ff : req_data.task_id;
   assign rd_in_range = ({1'b0, rd_id} < 9'(ftq_pkg::TASK_COUNT));

   // checks on the captured post id
   assign id_in_range = ({1'b0, id_ff} < 9'(ftq_pkg::TASK_COUNT));
   assign waiting     = id_in_range && ((rd_next != ftq_pkg::NONE_ID) || (tail_ff == id_ff));

   // next-state and table update
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      req_type_in  = req_type_ff;
      id_in        = id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      cmd.rd_en   = accept;
      cmd.rd_addr = rd_in_range ? rd_id[ftq_pkg::ADDR_W-1:0] : '0;
      cmd.wr_en   = 1'b0;
      cmd.wr_addr = tail_ff[ftq_pkg::ADDR_W-1:0];
      cmd.wr_data = id_ff;

      if (accept) begin
         req_type_in = req_data.req_type;
         id_in       = req_data.task_id;
         state_in    = ST_EXEC;
      end

      if (exec_go) begin
         rsp_data_in.ok          = 1'b0;
         rsp_data_in.popped_task = ftq_pkg::NONE_ID;
         if (req_type_ff == ftq_pkg::REQ_POST) begin
            // append unless out of range or already waiting
            if (id_in_range && !waiting) begin
               if (head_ff == ftq_pkg::NONE_ID) begin
                  head_in = id_ff;
               end else begin
                  cmd.wr_en = 1'b1;
               end
               tail_in = id_ff;
               rsp_data_in.ok = 1'b1;
            end
         end else begin
            // pop head and clear its link
            if (head_ff != ftq_pkg::NONE_ID) begin
               head_in = rd_next;
               if (rd_next == ftq_pkg::NONE_ID) begin
                  tail_in = ftq_pkg::NONE_ID;
               end
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = head_ff[ftq_pkg::ADDR_W-1:0];
               cmd.wr_data = ftq_pkg::NONE_ID;
               rsp_data_in.ok          = 1'b1;
               rsp_data_in.popped_task = head_ff;
            end
         end
         rsp_data_in.queue_empty = (head_in == ftq_pkg::NONE_ID);
         rsp_valid_in = 1'b1;
         state_in     = ST_IDLE;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= ftq_pkg::NONE_ID;
         tail_ff      <= ftq_pkg::NONE_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_type_ff <= req_type_in;
      id_ff       <= id_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // head and tail are none together
   `ASSERT_CLK(a_ends_agree, (head_ff == ftq_pkg::NONE_ID) == (tail_ff == ftq_pkg::NONE_ID))
   // a popped id always comes with ok
   `ASSERT_IMPLIES(a_pop_ok, rsp_valid_ff && (rsp_data_ff.popped_task != ftq_pkg::NONE_ID),
      rsp_data_ff.ok)
   // one request in flight at a time
   `ASSERT_IMPLIES(a_one_in_flight, accept, ##1 !req_ready)
   // a held result matches the queue state it left behind
   `ASSERT_IMPLIES(a_empty_flag, rsp_valid_ff && (state_ff == ST_IDLE),
      rsp_data_ff.queue_empty == (head_ff == ftq_pkg::NONE_ID))

endmodule

// ===== bench/fifo_task_queue_dedup_test.sv =====
// testbench for the linked-list task queue with dedup on post
// depends on ftq_pkg and fifo_task_queue_dedup; stand-alone, self-checking
`timescale 1ns / 1ps

module fifo_task_queue_dedup_test;

   localparam int STALL_CYCLES = 80;
   localparam int MAX_PRINTED = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   ftq_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   ftq_pkg::rsp_data_type rsp_data;

   // shadow of the queue: head, tail and the link table
   logic [ftq_pkg::ID_W-1:0] model_head;
   logic [ftq_pkg::ID_W-1:0] model_tail;
   logic [ftq_pkg::ID_W-1:0] model_link [ftq_pkg::TASK_COUNT];

   ftq_pkg::rsp_data_type expected_replies [$];

   bit calm_sender;
   bit calm_receiver;
   bit hold_armed;
   bit hold_started = 1'b0;
   int hold_left = 0;

   int error_count;
   int printed_count;
   int requests_sent;
   int posts_taken;
   int posts_refused;
   int pops_found;
   int pops_empty;

   fifo_task_queue_dedup u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic reset_model();
      model_head = ftq_pkg::NONE_ID;
      model_tail = ftq_pkg::NONE_ID;
      for (int i = 0; i < ftq_pkg::TASK_COUNT; i++) begin
         model_link[i] = ftq_pkg::NONE_ID;
      end
   endtask

   function automatic logic [ftq_pkg::ID_W-1:0] link_of(input logic [ftq_pkg::ID_W-1:0] id);
      if (int'(id) >= ftq_pkg::TASK_COUNT) begin
         return ftq_pkg::NONE_ID;
      end
      return model_link[id];
   endfunction

   // an id is waiting when it has a successor or sits at the tail
   function automatic bit id_pending(input logic [ftq_pkg::ID_W-1:0] id);
      return (int'(id) < ftq_pkg::TASK_COUNT) &&
             (link_of(id) != ftq_pkg::NONE_ID || model_tail == id);
   endfunction

   // one queue step: update the shadow state and return the reply beat
   function automatic ftq_pkg::rsp_data_type queue_step(input ftq_pkg::req_data_type beat);
      ftq_pkg::rsp_data_type    reply;
      logic [ftq_pkg::ID_W-1:0] cur;
      reply.ok = 1'b0;
      reply.popped_task = ftq_pkg::NONE_ID;
      if (beat.req_type == ftq_pkg::REQ_POST) begin
         if (int'(beat.task_id) < ftq_pkg::TASK_COUNT && !id_pending(beat.task_id)) begin
            if (model_head == ftq_pkg::NONE_ID) begin
               model_head = beat.task_id;
            end else begin
               model_link[model_tail] = beat.task_id;
            end
            model_tail = beat.task_id;
            reply.ok = 1'b1;
         end
      end else if (model_head != ftq_pkg::NONE_ID) begin
         cur = model_head;
         model_head = link_of(cur);
         if (model_head == ftq_pkg::NONE_ID) begin
            model_tail = ftq_pkg::NONE_ID;
         end
         model_link[cur] = ftq_pkg::NONE_ID;
         reply.popped_task = cur;
         reply.ok = 1'b1;
      end
      reply.queue_empty = (model_head == ftq_pkg::NONE_ID);
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (printed_count < MAX_PRINTED) begin
         printed_count++;
         $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
      end
   endtask

   // offer one request beat, optionally after a random gap, and wait for it
   task automatic send_request(input logic kind, input logic [ftq_pkg::ID_W-1:0] id);
      ftq_pkg::req_data_type beat;
      ftq_pkg::rsp_data_type reply;
      int                    gap;
      beat.req_type = kind;
      beat.task_id = id;
      if (!calm_sender && $urandom_range(99) < 22) begin
         gap = 1 + (($urandom_range(99) < 30) ? int'($urandom_range(6)) : 0);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      reply = queue_step(beat);
      expected_replies.push_back(reply);
      requests_sent++;
      if (kind == ftq_pkg::REQ_POP) begin
         if (reply.ok) begin
            pops_found++;
         end else begin
            pops_empty++;
         end
      end else if (reply.ok) begin
         posts_taken++;
      end else begin
         posts_refused++;
      end
   endtask

   // reply side: random back-pressure, long hold when asked, and checking
   always @(posedge clock) begin : check_reply
      ftq_pkg::rsp_data_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && (calm_receiver || $urandom_range(99) >= 22);
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with nothing expected, popped_task",
                               int'(rsp_data.popped_task), int'(ftq_pkg::NONE_ID));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.ok !== want.ok) begin
                  report_mismatch("ok", int'(rsp_data.ok), int'(want.ok));
               end
               if (rsp_data.popped_task !== want.popped_task) begin
                  report_mismatch("popped_task", int'(rsp_data.popped_task),
                                  int'(want.popped_task));
               end
               if (rsp_data.queue_empty !== want.queue_empty) begin
                  report_mismatch("queue_empty", int'(rsp_data.queue_empty),
                                  int'(want.queue_empty));
               end
            end
         end
      end
   end

   // long receiver hold: load once when armed, then count down
   always @(posedge clock) begin
      if (hold_armed && !hold_started) begin
         hold_started <= 1'b1;
         hold_left <= STALL_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // post id picker: biased to low ids so duplicates come up often
   function automatic logic [ftq_pkg::ID_W-1:0] pick_post_id();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8 && model_tail != ftq_pkg::NONE_ID) begin
         return model_tail;
      end
      if (roll < 13) begin
         return ftq_pkg::NONE_ID;
      end
      if (roll < 30) begin
         return 8'($urandom_range(255));
      end
      if (roll < 65) begin
         return 8'($urandom_range(15));
      end
      return 8'($urandom_range(ftq_pkg::TASK_COUNT - 1));
   endfunction

   // extremes, duplicates, bad id, empty pops and re-post after pop
   task automatic test_directed();
      send_request(ftq_pkg::REQ_POP, 8'h00);
      send_request(ftq_pkg::REQ_POST, ftq_pkg::NONE_ID);
      send_request(ftq_pkg::REQ_POST, 8'h00);
      send_request(ftq_pkg::REQ_POST, 8'h00);
      send_request(ftq_pkg::REQ_POST, 8'(ftq_pkg::TASK_COUNT - 1));
      send_request(ftq_pkg::REQ_POST, 8'h00);
      send_request(ftq_pkg::REQ_POST, 8'h80);
      send_request(ftq_pkg::REQ_POST, 8'(ftq_pkg::TASK_COUNT - 1));
      send_request(ftq_pkg::REQ_POST, ftq_pkg::NONE_ID);
      send_request(ftq_pkg::REQ_POP, 8'hAA);
      send_request(ftq_pkg::REQ_POST, 8'h00);
      send_request(ftq_pkg::REQ_POP, 8'h55);
      send_request(ftq_pkg::REQ_POP, ftq_pkg::NONE_ID);
      send_request(ftq_pkg::REQ_POP, 8'h00);
      send_request(ftq_pkg::REQ_POP, 8'h00);
      send_request(ftq_pkg::REQ_POP, 8'hFF);
      send_request(ftq_pkg::REQ_POST, 8'h01);
      send_request(ftq_pkg::REQ_POP, 8'h01);
      send_request(ftq_pkg::REQ_POST, 8'h01);
      send_request(ftq_pkg::REQ_POST, 8'h01);
      send_request(ftq_pkg::REQ_POP, 8'h7F);
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_pressure();
      hold_armed = 1'b1;
      for (int i = 0; i < 24; i++) begin
         if ($urandom_range(99) < 70) begin
            send_request(ftq_pkg::REQ_POST, pick_post_id());
         end else begin
            send_request(ftq_pkg::REQ_POP, 8'($urandom_range(255)));
         end
      end
   endtask

   // every id in shuffled order, posts against a full queue, then drain past empty
   task automatic test_fill_and_drain();
      logic [ftq_pkg::ID_W-1:0] order [ftq_pkg::TASK_COUNT];
      logic [ftq_pkg::ID_W-1:0] swap;
      int                       j;
      for (int i = 0; i < ftq_pkg::TASK_COUNT; i++) begin
         order[i] = 8'(i);
      end
      for (int i = ftq_pkg::TASK_COUNT - 1; i > 0; i--) begin
         j = int'($urandom_range(i));
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < ftq_pkg::TASK_COUNT; i++) begin
         send_request(ftq_pkg::REQ_POST, order[i]);
      end
      for (int i = 0; i < 8; i++) begin
         send_request(ftq_pkg::REQ_POST, 8'($urandom_range(255)));
      end
      for (int i = 0; i <= ftq_pkg::TASK_COUNT; i++) begin
         send_request(ftq_pkg::REQ_POP, 8'($urandom_range(255)));
      end
   endtask

   // bursts that lean to posting or popping so the queue depth wanders
   task automatic test_random_mix(input int count);
      int sent;
      int burst;
      int post_pct;
      sent = 0;
      while (sent < count) begin
         burst = 1 + int'($urandom_range(40));
         case ($urandom_range(2))
            0: post_pct = 25;
            1: post_pct = 50;
            default: post_pct = 80;
         endcase
         for (int i = 0; i < burst; i++) begin
            if ($urandom_range(99) < post_pct) begin
               send_request(ftq_pkg::REQ_POST, pick_post_id());
            end else begin
               send_request(ftq_pkg::REQ_POP, 8'($urandom_range(255)));
            end
         end
         sent += burst;
      end
   endtask

   initial begin
      error_count = 0;
      printed_count = 0;
      requests_sent = 0;
      posts_taken = 0;
      posts_refused = 0;
      pops_found = 0;
      pops_empty = 0;
      calm_sender = 1'b0;
      calm_receiver = 1'b0;
      hold_armed = 1'b0;
      reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_pressure();
      test_fill_and_drain();
      test_random_mix(180);
      // stretch with no idling on either side
      calm_sender = 1'b1;
      calm_receiver = 1'b1;
      test_random_mix(100);
      calm_sender = 1'b0;
      calm_receiver = 1'b0;
      test_random_mix(80);
      req_valid <= 1'b0;

      while (expected_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d requests: %0d posts taken, %0d refused (duplicate or bad id),",
               requests_sent, posts_taken, posts_refused);
      $display("%0d pops found a task, %0d hit an empty queue; full queue and %0d-cycle stall",
               pops_found, pops_empty, STALL_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
